/* sv/assert_macros.svh */
// Assertion macros used by the statistics table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* sv/klst_pkg.sv */
// Types and constants of the keyed latency statistics table
package klst_pkg;
	localparam int unsigned LEVELS = 4;
	localparam int TABLE_DEPTH = 64;
	localparam logic [31:0] RAW_CAP = 32'd655294464;
	localparam logic [29:0] LOWEST_INIT = 30'd655294464;
	localparam logic [13:0] TALLY_CAP = 14'd9999;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_LOAD,
		ST_CAP,
		ST_DIV,
		ST_WRITE,
		ST_NEXT,
		ST_TRIM,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_OUT
	} state_t;

	// Divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage

/* sv/keyed_latency_stats_table_core.sv */
// Top level of the keyed latency statistics table
//
// One request channel (in_valid/in_stall) carries a record or a read
// request; one result channel (out_valid/out_stall) returns one result per
// request. A record searches the minute, hour, day and month tables in turn,
// one stored key per cycle, and runs the divider for each level whose total
// or tally overflows; it stops with status set at a full level that lacks
// the key. The search walks one memory read port; the divider is one bit
// per cycle. in_stall is high whenever a request is in progress or a result
// waits. Reset empties all tables (fill counts and oldest pointers go to
// zero) and loads the default limits 60, 24, 31 and 12. Limit writes via
// cfg_we, cfg_index and cfg_data take effect at once; the user must make
// them only while idle, as the core does not enforce this. A stalled
// result holds its value until it is taken.
`include "assert_macros.svh"
module keyed_latency_stats_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [39:0] now_time,
	input  logic [29:0] duration,
	input  logic [9:0]  resp_code,
	input  logic [7:0]  year_since_1900,
	input  logic [3:0]  month_of_year,
	input  logic [8:0]  day_of_year,
	input  logic [4:0]  hour_of_day,
	input  logic [5:0]  minute_of_hour,
	input  logic [1:0]  level,
	input  logic [5:0]  entry_index,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        entry_valid,
	output logic [8:0]  entry_key_first,
	output logic [8:0]  entry_key_second,
	output logic [9:0]  entry_resp,
	output logic [39:0] entry_first_time,
	output logic [39:0] entry_last_time,
	output logic [31:0] entry_total,
	output logic [13:0] entry_tally,
	output logic [29:0] entry_lowest,
	output logic [29:0] entry_highest,
	output logic [6:0]  level_count
);
	localparam int TABLE_DEPTH = klst_pkg::TABLE_DEPTH;
	localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = PW + 2;
	localparam int MD = 4 * TABLE_DEPTH;
	localparam int EW = 28 + 40 + 40 + 32 + 14 + 30 + 30;

	klst_pkg::state_t state_q, state_d;

	// Request registers
	logic [39:0] now_q;
	logic [29:0] dur_q;
	logic [27:0] key_q [4];
	logic [1:0]  lv_q;
	logic [5:0]  idx_q;

	logic [PW-1:0] oldest_q [4];
	logic [FW-1:0] fill_q [4];
	logic [5:0]    limit_q [4];

	logic [FW-1:0] age_q;
	logic [PW-1:0] slot_q;
	logic          found_q;
	logic          rd_pend_q;

	// Entry memory: one wide word per slot
	logic [EW-1:0] mem [MD];
	logic [EW-1:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [EW-1:0] wdata;
	logic          we;

	// Working entry
	logic [27:0] e_key;
	logic [39:0] e_first_q, e_last_q;
	logic [32:0] e_total_q;
	logic [13:0] e_tally_q;
	logic [29:0] e_low_q, e_high_q;

	// Output registers
	logic        ov_q;
	logic        st_q, ev_q;
	logic [EW-1:0] ent_q;
	logic [6:0]  cnt_q;

	klst_pkg::div_ctl_t div_ctl;
	klst_pkg::div_sts_t div_sts;
	logic [32:0] div_quo;

	klst_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl),
		.dividend(e_total_q), .divisor(e_tally_q), .sts(div_sts), .quotient(div_quo)
	);

	// Slot of age a in level lv
	function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] old,
			input logic [FW-1:0] age);
		logic [FW:0] p;
		begin
			p = {1'b0, {(FW-PW){1'b0}}, old} + {1'b0, age};
			if (p >= (FW+1)'(TABLE_DEPTH)) p = p - (FW+1)'(TABLE_DEPTH);
			slot_at = p[PW-1:0];
		end
	endfunction

	logic [PW-1:0] cur_slot;
	logic [PW-1:0] app_slot;
	logic          hit;
	logic          over;

	assign cur_slot = slot_at(oldest_q[lv_q], age_q);
	assign app_slot = slot_at(oldest_q[lv_q], fill_q[lv_q]);
	assign e_key = key_q[lv_q];
	assign hit = rd_pend_q && (rdata_q[EW-1 -: 28] == e_key);
	assign over = (e_tally_q > klst_pkg::TALLY_CAP) || (e_total_q > {1'b0, klst_pkg::RAW_CAP});

	// Memory port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		raddr = {lv_q, cur_slot};
		// Re-read the matching slot so its data is held for the load
		if (state_q == klst_pkg::ST_SEARCH && hit) raddr = {lv_q, slot_q};
		if (state_q == klst_pkg::ST_RD_ADDR) raddr = {lv_q, slot_at(oldest_q[lv_q], FW'(idx_q))};
		waddr = {lv_q, slot_q};
		we = (state_q == klst_pkg::ST_WRITE);
		wdata = {e_key, e_first_q, e_last_q, e_total_q[31:0], e_tally_q, e_low_q, e_high_q};
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= klst_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != klst_pkg::ST_IDLE) || ov_q;

	// Next state
	always_comb begin
		state_d = state_q;
		div_ctl.start = 1'b0;
		unique case (state_q)
			klst_pkg::ST_IDLE:
				if (accept) state_d = (opcode == klst_pkg::OP_READ) ?
					klst_pkg::ST_RD_ADDR : klst_pkg::ST_SEARCH;
			klst_pkg::ST_SEARCH:
				if (hit) state_d = klst_pkg::ST_LOAD;
				else if (!rd_pend_q && age_q >= fill_q[lv_q]) state_d = klst_pkg::ST_CHECK;
			klst_pkg::ST_CHECK:
				state_d = (fill_q[lv_q] >= FW'(TABLE_DEPTH)) ? klst_pkg::ST_OUT
					: klst_pkg::ST_LOAD;
			klst_pkg::ST_LOAD: state_d = klst_pkg::ST_CAP;
			klst_pkg::ST_CAP: begin
				if (over) begin
					div_ctl.start = 1'b1;
					state_d = klst_pkg::ST_DIV;
				end else state_d = klst_pkg::ST_WRITE;
			end
			klst_pkg::ST_DIV:
				if (div_sts.done) state_d = klst_pkg::ST_WRITE;
			klst_pkg::ST_WRITE: state_d = klst_pkg::ST_NEXT;
			klst_pkg::ST_NEXT:
				state_d = (lv_q == 2'd3) ? klst_pkg::ST_TRIM : klst_pkg::ST_SEARCH;
			klst_pkg::ST_TRIM: state_d = klst_pkg::ST_OUT;
			klst_pkg::ST_RD_ADDR: state_d = klst_pkg::ST_RD_DATA;
			klst_pkg::ST_RD_DATA: state_d = klst_pkg::ST_OUT;
			klst_pkg::ST_OUT: state_d = klst_pkg::ST_IDLE;
			default: state_d = klst_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				oldest_q[i] <= '0;
				fill_q[i] <= '0;
			end
			limit_q[0] <= 6'd60;
			limit_q[1] <= 6'd24;
			limit_q[2] <= 6'd31;
			limit_q[3] <= 6'd12;
			ov_q <= 1'b0;
			st_q <= 1'b0;
			age_q <= '0;
			slot_q <= '0;
			rd_pend_q <= 1'b0;
			found_q <= 1'b0;
			lv_q <= '0;
		end else begin
			if (cfg_we) limit_q[cfg_index] <= cfg_data;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				klst_pkg::ST_IDLE:
					if (accept) begin
						lv_q <= (opcode == klst_pkg::OP_READ) ? level : 2'd0;
						age_q <= '0;
						rd_pend_q <= 1'b0;
						st_q <= 1'b0;
					end
				klst_pkg::ST_SEARCH: begin
					// Read one slot per cycle, compare it in the next cycle
					found_q <= 1'b0;
					if (hit) begin
						found_q <= 1'b1;
						rd_pend_q <= 1'b0;
					end else if (age_q < fill_q[lv_q]) begin
						slot_q <= cur_slot;
						age_q <= age_q + FW'(1);
						rd_pend_q <= 1'b1;
					end else rd_pend_q <= 1'b0;
				end
				klst_pkg::ST_CHECK:
					if (fill_q[lv_q] >= FW'(TABLE_DEPTH)) st_q <= 1'b1;
					else begin
						slot_q <= app_slot;
						fill_q[lv_q] <= fill_q[lv_q] + FW'(1);
					end
				klst_pkg::ST_NEXT: begin
					lv_q <= lv_q + 2'd1;
					age_q <= '0;
					rd_pend_q <= 1'b0;
				end
				klst_pkg::ST_TRIM:
					if (fill_q[0] > FW'(limit_q[0])) begin
						for (int i = 0; i < 4; i++)
							if (i == 0 || fill_q[i] > FW'(limit_q[i])) begin
								fill_q[i] <= fill_q[i] - FW'(1);
								oldest_q[i] <= (oldest_q[i] == PW'(TABLE_DEPTH - 1)) ?
									'0 : oldest_q[i] + PW'(1);
							end
					end
				klst_pkg::ST_OUT: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_time;
			dur_q <= duration;
			idx_q <= entry_index;
			key_q[0] <= {4'd0, hour_of_day, 3'd0, minute_of_hour, resp_code};
			key_q[1] <= {day_of_year, 4'd0, hour_of_day, resp_code};
			key_q[2] <= {1'b0, year_since_1900, day_of_year, resp_code};
			key_q[3] <= {1'b0, year_since_1900, 5'd0, month_of_year, resp_code};
		end
		if (state_q == klst_pkg::ST_LOAD) begin
			// Fold the new duration into the working entry
			e_last_q <= now_q;
			if (found_q) begin
				e_first_q <= rdata_q[EW-29 -: 40];
				e_total_q <= {1'b0, rdata_q[105:74]} + 33'(dur_q);
				e_tally_q <= rdata_q[73:60] + 14'd1;
				e_low_q <= (dur_q < rdata_q[59:30]) ? dur_q : rdata_q[59:30];
				e_high_q <= (dur_q > rdata_q[29:0]) ? dur_q : rdata_q[29:0];
			end else begin
				e_first_q <= now_q;
				e_total_q <= 33'(dur_q);
				e_tally_q <= 14'd1;
				e_low_q <= (dur_q < klst_pkg::LOWEST_INIT) ? dur_q : klst_pkg::LOWEST_INIT;
				e_high_q <= dur_q;
			end
		end
		if (div_sts.done) begin
			e_total_q <= div_quo;
			e_tally_q <= 14'd1;
		end
		if (state_q == klst_pkg::ST_RD_DATA) begin
			cnt_q <= 7'(fill_q[lv_q]);
			ev_q <= FW'(idx_q) < fill_q[lv_q];
			ent_q <= (FW'(idx_q) < fill_q[lv_q]) ? rdata_q : '0;
		end else if (state_q == klst_pkg::ST_IDLE && accept) begin
			cnt_q <= '0;
			ev_q <= 1'b0;
			ent_q <= '0;
		end
	end

	// Result fields
	assign out_valid = ov_q;
	assign status = st_q;
	assign entry_valid = ev_q;
	assign entry_key_first = ent_q[EW-1 -: 9];
	assign entry_key_second = ent_q[EW-10 -: 9];
	assign entry_resp = ent_q[EW-19 -: 10];
	assign entry_first_time = ent_q[EW-29 -: 40];
	assign entry_last_time = ent_q[EW-69 -: 40];
	assign entry_total = ent_q[105:74];
	assign entry_tally = ent_q[73:60];
	assign entry_lowest = ent_q[59:30];
	assign entry_highest = ent_q[29:0];
	assign level_count = cnt_q;

	`CHK_SAME(a_stall_out, clk, arst_n, out_valid, in_stall, "request taken while result waits")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "stalled result lost")
	`CHK_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q[0] <= FW'(TABLE_DEPTH), "fill overflow")
endmodule

/* sv/klst_div.sv */
// Restoring divider: 33-bit dividend by 14-bit divisor, one quotient bit per cycle
module klst_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  klst_pkg::div_ctl_t   ctl,
	input  logic [32:0]          dividend,
	input  logic [13:0]          divisor,
	output klst_pkg::div_sts_t   sts,
	output logic [32:0]          quotient
);
	logic [32:0] quo_q;
	logic [14:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [14:0] trial;
	logic        fit;

	// Shift in the next dividend bit and try a subtraction
	always_comb begin
		trial = {rem_q[13:0], quo_q[32]};
		fit = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? (trial - {1'b0, divisor}) : trial;
			quo_q <= {quo_q[31:0], fit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;
endmodule

/* bench/keyed_latency_stats_table_core_tb.sv */
// Self-checking testbench for the keyed latency statistics table core
module keyed_latency_stats_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = klst_pkg::TABLE_DEPTH;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 450;
	localparam logic [1:0] LV_MINUTE = 2'd0;
	localparam logic [1:0] LV_HOUR = 2'd1;
	localparam logic [1:0] LV_DAY = 2'd2;
	localparam logic [1:0] LV_MONTH = 2'd3;
	localparam logic [1:0] REG_MINUTE_LIMIT = 2'd0;
	localparam logic [1:0] REG_HOUR_LIMIT = 2'd1;
	localparam logic [1:0] REG_DAY_LIMIT = 2'd2;
	localparam logic [1:0] REG_MONTH_LIMIT = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = klst_pkg::OP_RECORD;
	logic [39:0] now_time = '0;
	logic [29:0] duration = '0;
	logic [9:0]  resp_code = '0;
	logic [7:0]  year_since_1900 = '0;
	logic [3:0]  month_of_year = 4'd1;
	logic [8:0]  day_of_year = '0;
	logic [4:0]  hour_of_day = '0;
	logic [5:0]  minute_of_hour = '0;
	logic [1:0]  level = LV_MINUTE;
	logic [5:0]  entry_index = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MINUTE_LIMIT;
	logic [5:0]  cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic        entry_valid;
	logic [8:0]  entry_key_first;
	logic [8:0]  entry_key_second;
	logic [9:0]  entry_resp;
	logic [39:0] entry_first_time;
	logic [39:0] entry_last_time;
	logic [31:0] entry_total;
	logic [13:0] entry_tally;
	logic [29:0] entry_lowest;
	logic [29:0] entry_highest;
	logic [6:0]  level_count;

	typedef struct {
		logic        op;
		logic [39:0] now;
		logic [29:0] dur;
		logic [9:0]  resp;
		logic [7:0]  year;
		logic [3:0]  month;
		logic [8:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [1:0]  lv;
		logic [5:0]  idx;
	} request_t;

	typedef struct {
		logic [27:0] key;
		logic [39:0] first;
		logic [39:0] last;
		logic [31:0] total;
		logic [13:0] tally;
		logic [29:0] lowest;
		logic [29:0] highest;
	} stats_entry_t;

	typedef struct {
		logic        status;
		logic        valid;
		logic [8:0]  key_first;
		logic [8:0]  key_second;
		logic [9:0]  resp;
		logic [39:0] first;
		logic [39:0] last;
		logic [31:0] total;
		logic [13:0] tally;
		logic [29:0] lowest;
		logic [29:0] highest;
		logic [6:0]  count;
	} stats_result_t;

	stats_entry_t  stats_table [4][DEPTH];
	int            table_fill [4];
	int            table_oldest [4];
	logic [5:0]    table_limit [4];
	stats_result_t expected_results [$];
	int            errors = 0;
	bit            pace = 1'b1;
	int            result_hold = 0;
	int            quiet_cycles = 0;

	keyed_latency_stats_table_core dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int slot_at(int lv, int age);
		int p;
		p = table_oldest[lv] + age;
		if (p >= DEPTH) p -= DEPTH;
		return p;
	endfunction

	function automatic void drop_oldest(int lv);
		if (table_fill[lv] == 0) return;
		table_oldest[lv] = (table_oldest[lv] + 1) % DEPTH;
		table_fill[lv]--;
	endfunction

	// Update one level; return 0 when the level is full and the key is absent
	function automatic bit update_level(int lv, logic [27:0] key, logic [39:0] now,
			logic [29:0] dur);
		int s;
		int age;
		bit hit;
		longint unsigned sum;
		longint unsigned cnt;
		hit = 1'b0;
		s = 0;
		age = 0;
		while (!hit && age < table_fill[lv]) begin
			s = slot_at(lv, age);
			if (stats_table[lv][s].key == key) hit = 1'b1;
			age++;
		end
		if (!hit) begin
			if (table_fill[lv] >= DEPTH) return 1'b0;
			s = slot_at(lv, table_fill[lv]);
			stats_table[lv][s].key = key;
			stats_table[lv][s].first = now;
			stats_table[lv][s].total = '0;
			stats_table[lv][s].tally = '0;
			stats_table[lv][s].lowest = klst_pkg::LOWEST_INIT;
			stats_table[lv][s].highest = '0;
			table_fill[lv]++;
		end
		stats_table[lv][s].last = now;
		sum = longint'(stats_table[lv][s].total) + longint'(dur);
		cnt = longint'(stats_table[lv][s].tally) + 1;
		// fold into the average when either count or sum runs over its cap
		if (cnt > longint'(klst_pkg::TALLY_CAP) || sum > longint'(klst_pkg::RAW_CAP)) begin
			sum = sum / cnt;
			cnt = 1;
		end
		stats_table[lv][s].total = sum[31:0];
		stats_table[lv][s].tally = cnt[13:0];
		if (dur < stats_table[lv][s].lowest) stats_table[lv][s].lowest = dur;
		if (dur > stats_table[lv][s].highest) stats_table[lv][s].highest = dur;
		return 1'b1;
	endfunction

	function automatic stats_result_t stats_predict(request_t r);
		stats_result_t res;
		logic [27:0] keys [4];
		int s;
		res = '{default: '0};
		if (r.op == klst_pkg::OP_RECORD) begin
			keys[0] = {9'(r.hour), 9'(r.minute), r.resp};
			keys[1] = {r.day, 9'(r.hour), r.resp};
			keys[2] = {9'(r.year), r.day, r.resp};
			keys[3] = {9'(r.year), 9'(r.month), r.resp};
			for (int i = 0; i < 4; i++) begin
				if (!update_level(i, keys[i], r.now, r.dur)) begin
					res.status = 1'b1;
					return res;
				end
			end
			// trim upper levels only when the minute level overflows
			if (table_fill[0] > table_limit[0]) begin
				drop_oldest(0);
				for (int i = 1; i < 4; i++)
					if (table_fill[i] > table_limit[i]) drop_oldest(i);
			end
			return res;
		end
		res.count = 7'(table_fill[r.lv]);
		if (r.idx < table_fill[r.lv]) begin
			s = slot_at(r.lv, r.idx);
			res.valid = 1'b1;
			res.key_first = stats_table[r.lv][s].key[27:19];
			res.key_second = stats_table[r.lv][s].key[18:10];
			res.resp = stats_table[r.lv][s].key[9:0];
			res.first = stats_table[r.lv][s].first;
			res.last = stats_table[r.lv][s].last;
			res.total = stats_table[r.lv][s].total;
			res.tally = stats_table[r.lv][s].tally;
			res.lowest = stats_table[r.lv][s].lowest;
			res.highest = stats_table[r.lv][s].highest;
		end
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endfunction

	// Compare results, pace the result side and watch for a hang
	always @(posedge clk) begin
		stats_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = expected_results.pop_front();
				check_field("status", e.status, status);
				check_field("entry_valid", e.valid, entry_valid);
				check_field("entry_key_first", e.key_first, entry_key_first);
				check_field("entry_key_second", e.key_second, entry_key_second);
				check_field("entry_resp", e.resp, entry_resp);
				check_field("entry_first_time", e.first, entry_first_time);
				check_field("entry_last_time", e.last, entry_last_time);
				check_field("entry_total", e.total, entry_total);
				check_field("entry_tally", e.tally, entry_tally);
				check_field("entry_lowest", e.lowest, entry_lowest);
				check_field("entry_highest", e.highest, entry_highest);
				check_field("level_count", e.count, level_count);
			end
			result_hold = pace ? $urandom_range(0, 10) : 0;
		end else if (out_valid && result_hold > 0) begin
			result_hold--;
		end
		out_stall <= (result_hold > 0);
		if ((out_valid && !out_stall) || (in_valid && !in_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("keyed_latency_stats_table_core_tb: done, errors");
			$finish;
		end
	end

	task automatic send_request(request_t r);
		int gap;
		gap = pace ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode <= r.op;
		now_time <= r.now;
		duration <= r.dur;
		resp_code <= r.resp;
		year_since_1900 <= r.year;
		month_of_year <= r.month;
		day_of_year <= r.day;
		hour_of_day <= r.hour;
		minute_of_hour <= r.minute;
		level <= r.lv;
		entry_index <= r.idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(stats_predict(r));
	endtask

	// Hold off until every result is back and the core has settled
	task automatic drain();
		in_valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(logic [1:0] idx, logic [5:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_limit[idx] = val;
		@(posedge clk);
	endtask

	task automatic set_all_limits(logic [5:0] m, logic [5:0] h, logic [5:0] d,
			logic [5:0] mo);
		drain();
		set_limit(REG_MINUTE_LIMIT, m);
		set_limit(REG_HOUR_LIMIT, h);
		set_limit(REG_DAY_LIMIT, d);
		set_limit(REG_MONTH_LIMIT, mo);
	endtask

	function automatic request_t record_req(logic [39:0] now, logic [29:0] dur,
			logic [9:0] resp, logic [7:0] year, logic [3:0] month, logic [8:0] day,
			logic [4:0] hour, logic [5:0] minute);
		request_t r;
		r = '{op: klst_pkg::OP_RECORD, now: now, dur: dur, resp: resp, year: year,
			month: month, day: day, hour: hour, minute: minute, lv: LV_MINUTE, idx: '0};
		return r;
	endfunction

	function automatic request_t read_req(logic [1:0] lv, logic [5:0] idx);
		request_t r;
		r = record_req('0, '0, '0, '0, 4'd1, '0, '0, '0);
		r.op = klst_pkg::OP_READ;
		r.lv = lv;
		r.idx = idx;
		return r;
	endfunction

	function automatic request_t random_req();
		request_t r;
		bit pooled;
		pooled = ($urandom_range(0, 9) < 8);
		r.op = ($urandom_range(0, 9) < 3) ? klst_pkg::OP_READ : klst_pkg::OP_RECORD;
		r.now = 40'({$urandom, $urandom});
		r.dur = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, 1 << 22));
		r.resp = pooled ? 10'(200 + 100 * $urandom_range(0, 3)) : 10'($urandom_range(0, 999));
		r.year = pooled ? 8'($urandom_range(120, 121)) : 8'($urandom_range(0, 255));
		r.month = pooled ? 4'($urandom_range(1, 2)) : 4'($urandom_range(1, 12));
		r.day = pooled ? 9'($urandom_range(0, 2)) : 9'($urandom_range(0, 365));
		r.hour = pooled ? 5'($urandom_range(0, 2)) : 5'($urandom_range(0, 23));
		r.minute = pooled ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 59));
		r.lv = 2'($urandom_range(0, 3));
		r.idx = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
		return r;
	endfunction

	// Read every level at both ends while the tables are empty
	task automatic test_empty_reads();
		for (int lv = 0; lv < 4; lv++) begin
			send_request(read_req(2'(lv), 6'd0));
			send_request(read_req(2'(lv), 6'd63));
		end
	endtask

	// Extremes of every field, plus the sum running past 9999 s
	task automatic test_field_extremes();
		send_request(record_req('0, '0, '0, '0, 4'd1, '0, '0, '0));
		send_request(record_req('1, '1, 10'd999, 8'd255, 4'd12, 9'd365, 5'd23, 6'd59));
		drain();
		send_request(record_req(40'd5, 30'd6000 << 16, 10'd500, 8'd1, 4'd3, 9'd7, 5'd4, 6'd9));
		send_request(record_req(40'd6, 30'd6000 << 16, 10'd500, 8'd1, 4'd3, 9'd7, 5'd4, 6'd9));
		send_request(record_req(40'd7, 30'd1, 10'd500, 8'd1, 4'd3, 9'd7, 5'd4, 6'd9));
		for (int lv = 0; lv < 4; lv++)
			for (int i = 0; i < 3; i++)
				send_request(read_req(2'(lv), 6'(i)));
	endtask

	// Many back-to-back hits on one key with long durations, folding the total often
	task automatic test_average_fold();
		pace = 1'b0;
		for (int i = 0; i < 200; i++)
			send_request(record_req(40'(i), 30'($urandom_range(1 << 27, 1 << 29)), 10'd301,
				8'd2, 4'd5, 9'd40, 5'd11, 6'd30));
		pace = 1'b1;
		for (int lv = 0; lv < 4; lv++)
			for (int i = 0; i < 5; i++)
				send_request(read_req(2'(lv), 6'(i)));
	endtask

	// Fill the hour and day levels, then let records stop on each of them in turn
	task automatic test_full_tables();
		set_all_limits(6'd63, 6'd63, 6'd63, 6'd63);
		for (int d = 0; d < 70; d++)
			send_request(record_req(40'(d), 30'($urandom), 10'd777, 8'd50, 4'd6,
				9'(d), 5'd3, 6'd3));
		for (int y = 0; y < 70; y++)
			send_request(record_req(40'(y), 30'($urandom), 10'd777, 8'(y), 4'd6,
				9'd0, 5'd3, 6'd3));
		for (int lv = 0; lv < 4; lv++) begin
			send_request(read_req(2'(lv), 6'd0));
			send_request(read_req(2'(lv), 6'd63));
		end
	endtask

	// Random traffic under several limit settings
	task automatic test_random_traffic();
		set_all_limits(6'd0, 6'd0, 6'd0, 6'd0);
		for (int i = 0; i < 150; i++) send_request(random_req());
		set_all_limits(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		for (int i = 0; i < 400; i++) send_request(random_req());
		set_all_limits(6'd8, 6'd5, 6'd3, 6'd2);
		for (int i = 0; i < 300; i++) begin
			if (i == 150) drain();
			send_request(random_req());
		end
		set_all_limits(6'd60, 6'd24, 6'd31, 6'd12);
		for (int i = 0; i < 300; i++) send_request(random_req());
	endtask

	initial begin
		table_fill = '{default: 0};
		table_oldest = '{default: 0};
		table_limit = '{6'd60, 6'd24, 6'd31, 6'd12};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_reads();
		test_field_extremes();
		test_average_fold();
		test_full_tables();
		test_random_traffic();
		drain();
		if (errors == 0)
			$display("keyed_latency_stats_table_core_tb: done, clean");
		else
			$display("keyed_latency_stats_table_core_tb: done, errors");
		$finish;
	end
endmodule
